FILE: hw/rtl/hsd_pkg.sv
`timescale 1ns / 1ps

package hsd_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 10;   // sample code, center code, offset
    localparam int DUTY_W   = 8;    // duty and its limits
    localparam int SUM_W    = 14;   // calibration accumulator
    localparam int CNT_W    = 4;    // calibration sample counter
    localparam int CFG_W    = SAMPLE_W;
    localparam int CFG_AW   = 2;

    // ADC resolution; samples are scaled down to 8 bits by ADC_BITS - 8
    localparam int ADC_BITS = SAMPLE_W;

    // Reset values of the configuration registers
    localparam logic [SAMPLE_W-1:0] CENTER_RST   = SAMPLE_W'(512);
    localparam logic [DUTY_W-1:0]   DUTY_MIN_RST = DUTY_W'(5);
    localparam logic [DUTY_W-1:0]   DUTY_MAX_RST = DUTY_W'(250);

    // Upper end of the duty mapping input range
    localparam logic [DUTY_W-1:0] IN_SPAN = DUTY_W'(255);

    // Reciprocal divide of the calibration sum: exact for any SUM_W-bit sum
    // and any divisor up to 2**CNT_W.
    localparam int DIV_SHIFT  = SUM_W + CNT_W;
    localparam int DIV_MULT_W = DIV_SHIFT + 1;

    typedef enum logic [CFG_AW-1:0] {
        CFG_CENTER_CODE = 2'd0,
        CFG_DUTY_MIN    = 2'd1,
        CFG_DUTY_MAX    = 2'd2
    } cfg_addr_t;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_TICK   = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] offset;
    } cal_status_t;

endpackage

FILE: hw/rtl/hall_sensor_to_pwm_duty_unit.sv
`timescale 1ns / 1ps

// Channel   | Direction | Payload
// ----------+-----------+---------------------------------------------------
// s_*       | in        | tdata: sample_code[9:0]; tuser: kind[0]
// m_*       | out       | tdata: duty[7:0], offset_value[17:8]; tuser: updated[0],
//           |           |        calibrated[1]
// cfg_*     | in        | write only: 0 center_code, 1 duty_min, 2 duty_max
//
// One transfer per cycle sustained while no tick is stalled. An accepted item
// is processed from the input register; a tick's result is loaded into the
// output register, which drives m_tvalid.
// Sample events produce no result; ticks produce exactly one.
// Reset is synchronous, active low; config registers return to 512/5/250.
// A tick stalls in the input register only while the output register holds
// an untaken result; sample events pass through regardless.

module hall_sensor_to_pwm_duty_unit
    import hsd_pkg::*;
#(
    parameter int CAL_SAMPLES = 10
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,    // [9:0] sample_code
    input  logic [0:0]        s_tuser,    // [0] kind

    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,    // [7:0] duty, [17:8] offset_value
    output logic [1:0]        m_tuser,    // [0] updated, [1] calibrated

    input  logic              cfg_wr_en,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    localparam int SCALE_SHIFT = ADC_BITS - 8;

    // Configuration registers
    logic [SAMPLE_W-1:0] center_reg;
    logic [DUTY_W-1:0]   duty_min_reg;
    logic [DUTY_W-1:0]   duty_max_reg;

    // Input register
    logic                in_valid_reg;
    item_kind_t          in_kind_reg;
    logic [SAMPLE_W-1:0] in_code_reg;

    // Block state
    logic [SAMPLE_W-1:0] latest_reg,    latest_next;
    logic                ready_reg,     ready_next;
    logic [SAMPLE_W-1:0] last_tick_reg, last_tick_next;
    logic [DUTY_W-1:0]   duty_reg,      duty_next;

    // Output register
    logic                out_valid_reg;
    logic [DUTY_W-1:0]   out_duty_reg;
    logic                out_updated_reg;
    logic                out_cal_reg;
    logic [SAMPLE_W-1:0] out_offset_reg;

    logic                out_free;
    logic                fire;
    logic                is_tick;
    logic                sample_en;
    logic                upd_cond;
    logic                updated;
    logic [SAMPLE_W-1:0] scaled;
    logic                map_changed;
    logic [DUTY_W-1:0]   map_duty;
    cal_status_t         cal;

    // Handshake: output register frees when empty or being taken
    assign out_free  = !out_valid_reg || m_tready;
    assign is_tick   = (in_kind_reg == KIND_TICK);
    assign fire      = in_valid_reg && (!is_tick || out_free);
    assign s_tready  = !in_valid_reg || fire;
    assign sample_en = fire && !is_tick;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_reg   <= CENTER_RST;
            duty_min_reg <= DUTY_MIN_RST;
            duty_max_reg <= DUTY_MAX_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_CENTER_CODE: center_reg   <= cfg_wdata[SAMPLE_W-1:0];
                CFG_DUTY_MIN:    duty_min_reg <= cfg_wdata[DUTY_W-1:0];
                CFG_DUTY_MAX:    duty_max_reg <= cfg_wdata[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_kind_reg <= item_kind_t'(s_tuser[0]);
            in_code_reg <= s_tdata[SAMPLE_W-1:0];
        end
    end

    hsd_calib #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_calib (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .sample_en   (sample_en),
        .sample_code (in_code_reg),
        .center_code (center_reg),
        .status      (cal)
    );

    // Scale the stored sample down to 8-bit range
    assign scaled = latest_reg >> SCALE_SHIFT;

    hsd_duty_map u_map (
        .scaled   (scaled),
        .offset   (cal.offset),
        .duty_min (duty_min_reg),
        .duty_max (duty_max_reg),
        .changed  (map_changed),
        .duty_new (map_duty)
    );

    always_comb begin
        latest_next    = latest_reg;
        ready_next     = ready_reg;
        last_tick_next = last_tick_reg;
        duty_next      = duty_reg;
        upd_cond       = cal.done && ready_reg && (last_tick_reg != latest_reg);
        updated        = 1'b0;

        if (fire) begin
            if (!is_tick) begin
                latest_next = in_code_reg;
                // samples taken during calibration never become ready
                if (cal.done) begin
                    ready_next = 1'b1;
                end
            end else begin
                if (upd_cond) begin
                    ready_next = 1'b0;
                    updated    = map_changed;
                    if (map_changed) begin
                        duty_next = map_duty;
                    end
                end
                last_tick_next = latest_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latest_reg    <= '0;
            ready_reg     <= 1'b0;
            last_tick_reg <= '0;
            duty_reg      <= '0;
        end else begin
            latest_reg    <= latest_next;
            ready_reg     <= ready_next;
            last_tick_reg <= last_tick_next;
            duty_reg      <= duty_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && is_tick) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && is_tick) begin
            out_duty_reg    <= duty_next;
            out_updated_reg <= updated;
            out_cal_reg     <= cal.done;
            out_offset_reg  <= cal.offset;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_offset_reg, out_duty_reg};
    assign m_tuser  = {out_cal_reg, out_updated_reg};

endmodule

FILE: hw/rtl/hsd_calib.sv
`timescale 1ns / 1ps

module hsd_calib
    import hsd_pkg::*;
#(
    parameter int CAL_SAMPLES = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                sample_en,
    input  logic [SAMPLE_W-1:0] sample_code,
    input  logic [SAMPLE_W-1:0] center_code,
    output cal_status_t         status
);

    localparam logic [DIV_MULT_W-1:0] DIV_MULT =
        DIV_MULT_W'(((1 << DIV_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES);
    localparam logic [CNT_W-1:0] CAL_LAST = CNT_W'(CAL_SAMPLES);

    logic [CNT_W-1:0]             count_reg,  count_next;
    logic [SUM_W-1:0]             sum_reg,    sum_next;
    logic [SAMPLE_W-1:0]          offset_reg, offset_next;
    logic                         done_reg,   done_next;
    logic [SUM_W+DIV_MULT_W-1:0]  prod;
    logic [SUM_W-1:0]             avg;
    logic [SUM_W-1:0]             center_ext;
    logic [SUM_W-1:0]             diff;

    always_comb begin
        count_next  = count_reg;
        sum_next    = sum_reg;
        offset_next = offset_reg;
        done_next   = done_reg;

        // floor(sum / CAL_SAMPLES) by reciprocal multiply
        prod       = (SUM_W+DIV_MULT_W)'(sum_reg + SUM_W'(sample_code))
                   * (SUM_W+DIV_MULT_W)'(DIV_MULT);
        avg        = prod[DIV_SHIFT +: SUM_W];
        center_ext = SUM_W'(center_code);
        diff       = (avg > center_ext) ? (avg - center_ext) : (center_ext - avg);

        if (sample_en && !done_reg) begin
            count_next = count_reg + CNT_W'(1);
            sum_next   = sum_reg + SUM_W'(sample_code);
            if (count_next >= CAL_LAST) begin
                offset_next = diff[SAMPLE_W-1:0];
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            sum_reg    <= '0;
            offset_reg <= '0;
            done_reg   <= 1'b0;
        end else begin
            count_reg  <= count_next;
            sum_reg    <= sum_next;
            offset_reg <= offset_next;
            done_reg   <= done_next;
        end
    end

    assign status.done   = done_reg;
    assign status.offset = offset_reg;

endmodule

FILE: hw/rtl/hsd_duty_map.sv
`timescale 1ns / 1ps

module hsd_duty_map
    import hsd_pkg::*;
(
    input  logic [SAMPLE_W-1:0] scaled,
    input  logic [SAMPLE_W-1:0] offset,
    input  logic [DUTY_W-1:0]   duty_min,
    input  logic [DUTY_W-1:0]   duty_max,
    output logic                changed,
    output logic [DUTY_W-1:0]   duty_new
);

    logic [SAMPLE_W:0]   x;
    logic [DUTY_W-1:0]   span;
    logic [2*DUTY_W-1:0] prod;
    logic [2*DUTY_W:0]   q_sum;
    logic [DUTY_W-1:0]   quot;

    always_comb begin
        // x is zero only when scaled equals offset; changed is low in that case
        if (scaled < offset) begin
            x = (SAMPLE_W+1)'(scaled) + (SAMPLE_W+1)'(offset);
        end else begin
            x = (SAMPLE_W+1)'(scaled) - (SAMPLE_W+1)'(offset);
        end
        changed = (scaled != offset);

        span = duty_max - duty_min;
        prod = DUTY_W'(x[DUTY_W-1:0]) * span;
        // floor(prod / 255) for prod below 255*256
        q_sum = (2*DUTY_W+1)'(prod) + (2*DUTY_W+1)'(prod >> DUTY_W)
              + (2*DUTY_W+1)'(1);
        quot  = q_sum[DUTY_W +: DUTY_W];

        // Inverted limits collapse to duty_max for any positive x
        if (x >= (SAMPLE_W+1)'(IN_SPAN) || duty_max < duty_min) begin
            duty_new = duty_max;
        end else begin
            duty_new = duty_min + quot;
        end
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import hsd_pkg::*;

    localparam int CAL_SAMPLES = 10;
    localparam int PHASE_ITEMS = 104;   // random transfers per config phase
    localparam int SETTLE      = 8;     // cycles past the last result before a write

    // One input transfer: kind travels on tuser, the sample code on tdata
    typedef struct {
        item_kind_t          kind;
        logic [SAMPLE_W-1:0] code;
    } hall_event_t;

    // One result transfer, split into its fields
    typedef struct {
        logic [DUTY_W-1:0]   duty;
        logic                updated;
        logic                calibrated;
        logic [SAMPLE_W-1:0] offset;
    } duty_status_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [15:0]       s_tdata   = '0;   // [9:0] sample_code
    logic [0:0]        s_tuser   = '0;   // [0] kind

    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [23:0]       m_tdata;          // [7:0] duty, [17:8] offset_value
    logic [1:0]        m_tuser;          // [0] updated, [1] calibrated

    logic              cfg_wr_en = 1'b0;
    logic [CFG_AW-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    hall_sensor_to_pwm_duty_unit #(
        .CAL_SAMPLES(CAL_SAMPLES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wr_en(cfg_wr_en),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Stimulus queue, expected results, idle knobs
    hall_event_t  event_q[$];
    duty_status_t status_due[$];
    hall_event_t  drv_next;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           error_count   = 0;
    logic [SAMPLE_W-1:0] gen_last_code = '0;

    // Shadow copy of the config registers (reset values)
    logic [SAMPLE_W-1:0] cfg_center = CENTER_RST;
    logic [DUTY_W-1:0]   cfg_dmin   = DUTY_MIN_RST;
    logic [DUTY_W-1:0]   cfg_dmax   = DUTY_MAX_RST;

    // Shadow of the block state, all zero after reset
    logic [SAMPLE_W-1:0] hs_latest    = '0;
    logic                hs_ready     = 1'b0;
    logic [SAMPLE_W-1:0] hs_last_tick = '0;
    logic [CNT_W-1:0]    hs_cal_cnt   = '0;
    logic [SUM_W-1:0]    hs_cal_sum   = '0;
    logic [SAMPLE_W-1:0] hs_offset    = '0;
    logic [DUTY_W-1:0]   hs_duty      = '0;
    logic                hs_cal_done  = 1'b0;

    // Linear map of 0..255 onto dmin..dmax; the two clamps run in order so an
    // inverted min/max pair collapses to dmax for any positive x.
    function automatic logic [DUTY_W-1:0] scale_duty(input int x);
        int lo;
        int hi;
        int r;
        lo = int'(cfg_dmin);
        hi = int'(cfg_dmax);
        if (x <= 0)
            return cfg_dmin;
        if (x >= int'(IN_SPAN))
            return cfg_dmax;
        r = (x * (hi - lo)) / int'(IN_SPAN) + lo;
        if (r < lo)
            r = lo;
        if (r > hi)
            r = hi;
        return r[DUTY_W-1:0];
    endfunction

    // Advance the shadow state by one accepted transfer; ticks queue a result
    task automatic track_hall_event(input item_kind_t kind, input logic [SAMPLE_W-1:0] code);
        logic [SAMPLE_W-1:0] avg;
        logic [7:0]          s;
        logic                upd;
        duty_status_t        st;
        upd = 1'b0;
        if (kind == KIND_SAMPLE) begin
            hs_latest = code;
            if (!hs_cal_done) begin
                // calibration samples never become ready, the last one included
                hs_cal_sum = hs_cal_sum + SUM_W'(code);
                hs_cal_cnt = hs_cal_cnt + 1'b1;
                if (hs_cal_cnt >= CAL_SAMPLES) begin
                    avg = SAMPLE_W'(hs_cal_sum / CAL_SAMPLES);
                    // average equal to center leaves offset at zero
                    if (avg > cfg_center)
                        hs_offset = avg - cfg_center;
                    else if (avg < cfg_center)
                        hs_offset = cfg_center - avg;
                    hs_cal_done = 1'b1;
                end
            end else begin
                hs_ready = 1'b1;
            end
        end else begin
            if (hs_cal_done && hs_ready && hs_last_tick != hs_latest) begin
                s = 8'(hs_latest >> (ADC_BITS - 8));
                hs_ready = 1'b0;
                // offset stays on the 10-bit scale against the 8-bit s
                if (SAMPLE_W'(s) < hs_offset) begin
                    hs_duty = scale_duty(int'(s) + int'(hs_offset));
                    upd = 1'b1;
                end else if (SAMPLE_W'(s) > hs_offset) begin
                    hs_duty = scale_duty(int'(s) - int'(hs_offset));
                    upd = 1'b1;
                end
            end
            hs_last_tick    = hs_latest;
            st.duty         = hs_duty;
            st.updated      = upd;
            st.calibrated   = hs_cal_done;
            st.offset       = hs_offset;
            status_due.push_back(st);
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Driver: one transfer per handshake, random gaps per send_idle_pct
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                track_hall_event(item_kind_t'(s_tuser[0]), s_tdata[SAMPLE_W-1:0]);
            if (!s_tvalid || s_tready) begin
                if (event_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    drv_next = event_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= drv_next.kind;
                    s_tdata  <= 16'(drv_next.code);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each result transfer with the oldest expectation
    always @(posedge aclk) begin
        duty_status_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (status_due.size() == 0) begin
                    report_mismatch("unexpected result, duty", int'(m_tdata[7:0]), -1);
                end else begin
                    want = status_due.pop_front();
                    if (m_tdata[7:0] !== want.duty)
                        report_mismatch("duty", int'(m_tdata[7:0]), int'(want.duty));
                    if (m_tuser[0] !== want.updated)
                        report_mismatch("updated", int'(m_tuser[0]), int'(want.updated));
                    if (m_tuser[1] !== want.calibrated)
                        report_mismatch("calibrated", int'(m_tuser[1]), int'(want.calibrated));
                    if (m_tdata[17:8] !== want.offset)
                        report_mismatch("offset_value", int'(m_tdata[17:8]), int'(want.offset));
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_event(input item_kind_t kind, input int code);
        hall_event_t e;
        e.kind = kind;
        e.code = SAMPLE_W'(code);
        event_q.push_back(e);
    endtask

    // Ticks and samples with equal odds; repeats of the last code and codes that
    // land exactly on the offset hit the hold paths.
    function automatic hall_event_t random_event();
        hall_event_t e;
        int          r;
        r = $urandom_range(99);
        if (r < 50) begin
            e.kind = KIND_TICK;
            e.code = SAMPLE_W'($urandom_range(1023));
        end else begin
            e.kind = KIND_SAMPLE;
            if (r < 58)
                e.code = gen_last_code;
            else if (r < 66 && hs_offset <= 255)
                e.code = SAMPLE_W'((int'(hs_offset) << (ADC_BITS - 8)) + $urandom_range(3));
            else
                e.code = SAMPLE_W'($urandom_range(1023));
            gen_last_code = e.code;
        end
        return e;
    endfunction

    // Config write, only called with the block idle
    task automatic write_reg(input cfg_addr_t idx, input int value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= CFG_W'(value);
        case (idx)
            CFG_CENTER_CODE: cfg_center = SAMPLE_W'(value);
            CFG_DUTY_MIN:    cfg_dmin   = DUTY_W'(value);
            CFG_DUTY_MAX:    cfg_dmax   = DUTY_W'(value);
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Sender holds off until every transfer went in and every result came back
    task automatic drain();
        while (event_q.size() != 0 || s_tvalid)
            @(negedge aclk);
        while (status_due.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic run_phase(input int sidle, input int ridle, input int dmin, input int dmax,
                             input int center);
        write_reg(CFG_DUTY_MIN, dmin);
        write_reg(CFG_DUTY_MAX, dmax);
        write_reg(CFG_CENTER_CODE, center);
        send_idle_pct <= sidle;
        recv_idle_pct <= ridle;
        repeat (PHASE_ITEMS) event_q.push_back(random_event());
        drain();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct <= 9;
        recv_idle_pct <= 84;
        write_reg(CFG_CENTER_CODE, 512);
        write_reg(CFG_DUTY_MIN, 5);
        write_reg(CFG_DUTY_MAX, 250);

        // Calibration: sum 3620, average 362, offset 150 against center 512.
        // Ticks during calibration hold the duty.
        push_event(KIND_TICK, 1023);
        push_event(KIND_SAMPLE, 0);
        push_event(KIND_SAMPLE, 1023);
        push_event(KIND_TICK, 0);
        repeat (7) push_event(KIND_SAMPLE, 325);
        push_event(KIND_SAMPLE, 322);
        push_event(KIND_TICK, 0);        // last cal sample is not ready
        push_event(KIND_SAMPLE, 600);    // s equals offset: held
        push_event(KIND_TICK, 0);
        push_event(KIND_SAMPLE, 0);      // s below offset
        push_event(KIND_TICK, 1023);
        push_event(KIND_SAMPLE, 1023);   // s above offset, s at its top
        push_event(KIND_TICK, 0);
        push_event(KIND_SAMPLE, 1023);   // same as previous tick: no update
        push_event(KIND_TICK, 0);
        push_event(KIND_SAMPLE, 500);    // s + offset past 255: duty_max
        push_event(KIND_TICK, 0);
        push_event(KIND_SAMPLE, 604);    // x = 1
        push_event(KIND_TICK, 0);
        gen_last_code = 10'd604;
        drain();

        run_phase(9, 84, 5, 250, 1023);
        run_phase(9, 84, 0, 255, 0);
        run_phase(84, 9, 200, 50, 512);  // max below min
        run_phase(84, 9, 0, 0, 1);
        run_phase(0, 0, 255, 255, 1022);
        run_phase(0, 0, $urandom_range(255), $urandom_range(255), $urandom_range(1023));

        if (error_count == 0 && status_due.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/hsd_pkg.sv
hw/rtl/hsd_calib.sv
hw/rtl/hsd_duty_map.sv
hw/rtl/hall_sensor_to_pwm_duty_unit.sv
verif/tb_top.sv
